[src/brsc_pkg.sv]
// Package for the bivariate risk-set counter.
// Holds the field widths, the depth of the sample memories, the mode codes and
// the command and status structs between controller and datapath. No dependencies.
package brsc_pkg;

	localparam int DEPTH   = 1024;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int IDX_W   = 10;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 11;
	localparam int MODE_W  = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_INDEX = 2'd1,
		MODE_VALUE = 2'd2
	} mode_t;

	typedef struct packed {
		logic capture;
		logic wr_pair;
		logic rd_thr;
		logic thr_from_mem;
		logic thr_from_in;
		logic scan_rd;
		logic out_load;
		logic res_err;
	} ctl_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              load_ok;
		logic              index_ok;
		logic              n_zero;
		logic              scan_last;
	} dp_sts_t;

endpackage

[src/brsc_if.sv]
// Channel interfaces of the bivariate risk-set counter: request, result and
// configuration write, each with valid and ready. Depends on brsc_pkg.
interface brsc_req_if import brsc_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic [IDX_W-1:0]        index_first;
	logic [IDX_W-1:0]        index_second;
	logic signed [VAL_W-1:0] value_first;
	logic signed [VAL_W-1:0] value_second;

	modport source (output valid, mode, index_first, index_second, value_first, value_second,
		input ready);
	modport sink (input valid, mode, index_first, index_second, value_first, value_second,
		output ready);
endinterface

interface brsc_rsp_if import brsc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] at_risk_count;
	logic             status;

	modport source (output valid, at_risk_count, status, input ready);
	modport sink (input valid, at_risk_count, status, output ready);
endinterface

interface brsc_cfg_if import brsc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[src/brsc_datapath.sv]
// Datapath of the bivariate risk-set counter: request registers, the two sample
// memories, thresholds, scan address and hit counter, result register.
// Depends on brsc_pkg.
module brsc_datapath import brsc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctl_cmd_t                cmd,
	output dp_sts_t                 sts,
	input  logic [MODE_W-1:0]       req_mode,
	input  logic [IDX_W-1:0]        req_index_first,
	input  logic [IDX_W-1:0]        req_index_second,
	input  logic signed [VAL_W-1:0] req_value_first,
	input  logic signed [VAL_W-1:0] req_value_second,
	input  logic                    cfg_we,
	input  logic [CNT_W-1:0]        cfg_data,
	output logic [CNT_W-1:0]        at_risk_count,
	output logic                    status
);

	logic [MODE_W-1:0]       mode_q;
	logic [IDX_W-1:0]        j_q;
	logic [IDX_W-1:0]        i_q;
	logic signed [VAL_W-1:0] vf_q;
	logic signed [VAL_W-1:0] vs_q;
	logic [CNT_W-1:0]        sample_count_q;
	logic [CNT_W-1:0]        n;
	logic signed [VAL_W-1:0] mem_x [DEPTH];
	logic signed [VAL_W-1:0] mem_y [DEPTH];
	logic signed [VAL_W-1:0] rd_x_q;
	logic signed [VAL_W-1:0] rd_y_q;
	logic signed [VAL_W-1:0] a_q;
	logic signed [VAL_W-1:0] b_q;
	logic [ADDR_W-1:0]       k_q;
	logic [ADDR_W-1:0]       addr_x;
	logic [ADDR_W-1:0]       addr_y;
	logic                    cmp_s1;
	logic [CNT_W-1:0]        total_q;
	logic [CNT_W-1:0]        count_q;
	logic                    status_q;

	assign n = (sample_count_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : sample_count_q;

	assign addr_x = cmd.rd_thr ? ADDR_W'(j_q) : k_q;
	assign addr_y = cmd.rd_thr ? ADDR_W'(i_q) : k_q;

	always_comb begin
		sts.mode      = mode_q;
		sts.load_ok   = 32'(j_q) < 32'(DEPTH);
		sts.index_ok  = (CNT_W'(j_q) < n) && (CNT_W'(i_q) < n);
		sts.n_zero    = n == '0;
		sts.scan_last = CNT_W'(k_q) == (n - CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CNT_W'(1);
			cmp_s1         <= 1'b0;
		end else begin
			if (cfg_we) begin
				sample_count_q <= cfg_data;
			end
			cmp_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= req_mode;
			j_q    <= req_index_first;
			i_q    <= req_index_second;
			vf_q   <= req_value_first;
			vs_q   <= req_value_second;
		end
		if (cmd.wr_pair) begin
			mem_x[ADDR_W'(j_q)] <= vf_q;
			mem_y[ADDR_W'(j_q)] <= vs_q;
		end
		if (cmd.rd_thr || cmd.scan_rd) begin
			rd_x_q <= mem_x[addr_x];
			rd_y_q <= mem_y[addr_y];
		end
		if (cmd.thr_from_mem) begin
			a_q <= rd_x_q;
			b_q <= rd_y_q;
		end else if (cmd.thr_from_in) begin
			a_q <= vf_q;
			b_q <= vs_q;
		end
		if (cmd.capture) begin
			k_q     <= '0;
			total_q <= '0;
		end else begin
			if (cmd.scan_rd) begin
				k_q <= k_q + ADDR_W'(1);
			end
			if (cmp_s1 && (rd_x_q >= a_q) && (rd_y_q >= b_q)) begin
				total_q <= total_q + CNT_W'(1);
			end
		end
		if (cmd.out_load) begin
			count_q  <= cmd.res_err ? '0 : total_q;
			status_q <= cmd.res_err;
		end
	end

	assign at_risk_count = count_q;
	assign status        = status_q;

endmodule

[src/brsc_ctrl.sv]
// Controller of the bivariate risk-set counter: sequences load, threshold
// fetch, scan and result hand-off, and owns the request and result handshakes. Depends on brsc_pkg.
module brsc_ctrl import brsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_LATCH,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   err_q;
	logic   err_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		err_d   = err_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					err_d       = 1'b0;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (sts.mode)
					MODE_LOAD: begin
						cmd.wr_pair = sts.load_ok;
						err_d       = !sts.load_ok;
						state_d     = S_FINISH;
					end
					MODE_INDEX: begin
						if (sts.index_ok) begin
							cmd.rd_thr = 1'b1;
							state_d    = S_LATCH;
						end else begin
							err_d   = 1'b1;
							state_d = S_FINISH;
						end
					end
					MODE_VALUE: begin
						cmd.thr_from_in = 1'b1;
						state_d         = sts.n_zero ? S_FINISH : S_SCAN;
					end
					default: begin
						err_d   = 1'b1;
						state_d = S_FINISH;
					end
				endcase
			end
			S_LATCH: begin
				cmd.thr_from_mem = 1'b1;
				state_d          = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_err  = err_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/bivariate_risk_set_count_top.sv]
// Bivariate risk-set counter: stores up to DEPTH signed Q15.16 pairs (x, y) and
// counts how many of the first sample_count pairs have x >= a and y >= b, with
// a and b taken from stored entries (index mode) or given directly (value mode).
// A load writes its pair and goes on to the result; a query scans the first n pairs,
// where n = min(sample_count, DEPTH), reading one pair per cycle through the single
// read port of each sample memory; an index query first reads its thresholds. A flagged
// request and a value query with n = 0 skip the scan, like a load.
// One request is worked on at a time; a finished result sits in the output register,
// so the next request can be accepted while it waits to be taken. An index query with an index
// at or beyond n, or an undefined mode, returns status 1 with a count of zero.
// Depends on brsc_pkg, brsc_if, brsc_ctrl and brsc_datapath.
module bivariate_risk_set_count_top import brsc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	brsc_req_if.sink   req,
	brsc_rsp_if.source rsp,
	brsc_cfg_if.sink   cfg
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	assign cfg.ready = 1'b1;

	brsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brsc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_mode         (req.mode),
		.req_index_first  (req.index_first),
		.req_index_second (req.index_second),
		.req_value_first  (req.value_first),
		.req_value_second (req.value_second),
		.cfg_we           (cfg.valid),
		.cfg_data         (cfg.data),
		.at_risk_count    (rsp.at_risk_count),
		.status           (rsp.status)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a request was in progress");

	a_error_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.at_risk_count == '0)
		else $error("flagged result carries a nonzero count");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.at_risk_count <= CNT_W'(DEPTH))
		else $error("count exceeds the memory depth");

endmodule

[bench/brsc_risk_count_checker.sv]
`timescale 1ns / 100ps
// Checker for the bivariate risk-set counter: watches request, result and register beats,
// keeps its own copy of the stored pairs and the sample count, and compares every result.
// Depends on brsc_pkg and the channel interfaces in brsc_if.
module brsc_risk_count_checker import brsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	brsc_req_if  req,
	brsc_rsp_if  rsp,
	brsc_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding
);

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_FLAGGED = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] at_risk_count;
		logic             status;
	} risk_result_t;

	logic [VAL_W-1:0] pair_x [DEPTH];
	logic [VAL_W-1:0] pair_y [DEPTH];
	logic [CNT_W-1:0] pairs_configured;
	risk_result_t     awaited_results [$];
	int               bad = 0;

	assign mismatches = bad;

	function automatic int unsigned active_pairs();
		return (pairs_configured > DEPTH) ? DEPTH : pairs_configured;
	endfunction

	function automatic logic [CNT_W-1:0] dominance_total(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		int unsigned total;
		int unsigned k;
		total = 0;
		for (k = 0; k < active_pairs(); k++) begin
			if ($signed(pair_x[k]) >= a && $signed(pair_y[k]) >= b)
				total++;
		end
		return total[CNT_W-1:0];
	endfunction

	function automatic risk_result_t predict_risk(input logic [MODE_W-1:0] m,
			input logic [IDX_W-1:0] j, input logic [IDX_W-1:0] i,
			input logic signed [VAL_W-1:0] vf, input logic signed [VAL_W-1:0] vs);
		risk_result_t r;
		int unsigned n;
		n = active_pairs();
		r.at_risk_count = '0;
		r.status = STATUS_OK;
		case (m)
			MODE_LOAD: begin
				if (j < DEPTH) begin
					pair_x[j] = vf;
					pair_y[j] = vs;
				end else begin
					r.status = STATUS_FLAGGED;
				end
			end
			MODE_INDEX: begin
				if (j < n && i < n)
					r.at_risk_count = dominance_total(pair_x[j], pair_y[i]);
				else
					r.status = STATUS_FLAGGED;
			end
			MODE_VALUE: begin
				r.at_risk_count = dominance_total(vf, vs);
			end
			default: begin
				r.status = STATUS_FLAGGED;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		risk_result_t want;
		if (!arst_n) begin
			pairs_configured = 1;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t ns: result beat with none awaited, expected none, actual count %0d status %0d",
						$time, rsp.at_risk_count, rsp.status);
					bad++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.at_risk_count !== want.at_risk_count) begin
						$display("%0t ns: at_risk_count mismatch, expected %0d, actual %0d",
							$time, want.at_risk_count, rsp.at_risk_count);
						bad++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t ns: status mismatch, expected %0d, actual %0d",
							$time, want.status, rsp.status);
						bad++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				pairs_configured = cfg.data;
			if (req.valid && req.ready)
				awaited_results.push_back(predict_risk(req.mode, req.index_first,
					req.index_second, req.value_first, req.value_second));
			outstanding <= awaited_results.size();
		end
	end

endmodule

[bench/tb_bivariate_risk_set_count_top.sv]
`timescale 1ns / 100ps
// Top of the bench for the bivariate risk-set counter: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on brsc_pkg, brsc_if, the block
// and brsc_risk_count_checker.
module tb_bivariate_risk_set_count_top;
	import brsc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
	localparam logic [VAL_W-1:0]  VAL_MIN    = 32'h8000_0000;
	localparam logic [VAL_W-1:0]  VAL_MAX    = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0]  VAL_ONE    = 32'h0001_0000;
	localparam int                LONG_HOLD  = 300;

	logic clk;
	logic arst_n;

	brsc_req_if req_ch ();
	brsc_rsp_if rsp_ch ();
	brsc_cfg_if cfg_ch ();

	int fail_count;
	int outstanding;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_requests = 0;
	int holds_served;
	int hold_left;
	int beats_sent = 0;
	int unsigned n_active = 1;
	bit loaded [DEPTH];

	bivariate_risk_set_count_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	brsc_risk_count_checker count_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.mismatches  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Timeout with %0d results outstanding.", outstanding);
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return VAL_ONE;
			4: return (32'($urandom_range(6)) - 32'd3) << 16;
			5: return 32'($urandom_range(4)) - 32'd2;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_req(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] j,
			input logic [IDX_W-1:0] i, input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.index_first <= j;
		req_ch.index_second <= i;
		req_ch.value_first <= a;
		req_ch.value_second <= b;
		do @(posedge clk); while (!req_ch.ready);
		if (m == MODE_LOAD)
			loaded[j] = 1'b1;
		beats_sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_sample_count(input logic [CNT_W-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		n_active = (v > DEPTH) ? DEPTH : v;
	endtask

	task automatic random_item();
		int r;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] i;
		r = $urandom_range(99);
		j = IDX_W'($urandom_range(DEPTH - 1));
		i = IDX_W'($urandom_range(DEPTH - 1));
		if (n_active != 0 && $urandom_range(99) < 85) begin
			j = IDX_W'($urandom_range(n_active - 1));
			i = IDX_W'($urandom_range(n_active - 1));
		end
		if (r < 25)
			send_req(MODE_LOAD, j, i, pick_value(), pick_value());
		else if (r < 60)
			send_req(MODE_INDEX, j, i, $urandom, $urandom);
		else if (r < 95)
			send_req(MODE_VALUE, j, i, pick_value(), pick_value());
		else
			send_req(MODE_UNDEF, j, i, $urandom, $urandom);
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] v, input int send_pct, input int stall_pct,
			input int items, input bit with_pressure);
		int k;
		write_sample_count(v);
		send_idle_pct = 0;
		for (k = 0; k < n_active; k++) begin
			if (!loaded[k])
				send_req(MODE_LOAD, IDX_W'(k), IDX_W'($urandom), pick_value(), pick_value());
		end
		send_idle_pct = send_pct;
		rsp_stall_pct <= stall_pct;
		for (k = 0; k < items; k++) begin
			if (with_pressure && k == items / 3)
				hold_requests <= hold_requests + 1;
			if (with_pressure && k == 2 * items / 3)
				wait_drained();
			random_item();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_LOAD;
		req_ch.index_first <= '0;
		req_ch.index_second <= '0;
		req_ch.value_first <= '0;
		req_ch.value_second <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(MODE_LOAD, 0, 0, '0, '0);
		send_req(MODE_VALUE, 0, 0, '0, '0);
		send_req(MODE_VALUE, 0, 0, VAL_MIN, VAL_MIN);
		send_req(MODE_VALUE, 0, 0, VAL_MAX, VAL_MAX);
		send_req(MODE_VALUE, 0, 0, 32'd1, '0);
		send_req(MODE_INDEX, 0, 0, '0, '0);
		send_req(MODE_INDEX, 1, 0, '0, '0);
		send_req(MODE_INDEX, 0, IDX_W'(DEPTH - 1), '0, '0);
		send_req(MODE_UNDEF, IDX_W'($urandom), IDX_W'($urandom), $urandom, $urandom);
		send_req(MODE_LOAD, IDX_W'(DEPTH - 1), 10'h3FF, VAL_MAX, VAL_MIN);
		send_req(MODE_LOAD, 0, 0, VAL_MIN, VAL_MAX);
		send_req(MODE_INDEX, 0, 0, '0, '0);
		send_req(MODE_VALUE, 0, 0, VAL_MIN, VAL_MAX);
		send_req(MODE_VALUE, 0, 0, VAL_MIN + 32'd1, VAL_MAX);
		send_req(MODE_LOAD, 10'h2AA, 10'h155, 32'h5555_5555, 32'hAAAA_AAAA);
		send_req(MODE_LOAD, 10'h155, 10'h2AA, 32'hAAAA_AAAA, 32'h5555_5555);

		write_sample_count(0);
		send_req(MODE_VALUE, 0, 0, VAL_MIN, VAL_MIN);
		send_req(MODE_INDEX, 0, 0, '0, '0);
		send_req(MODE_UNDEF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(MODE_LOAD, 7, 0, VAL_ONE, VAL_ONE);

		run_phase(8, 0, 0, 80, 1'b0);
		run_phase(16, 70, 0, 80, 1'b0);
		run_phase(5, 0, 70, 80, 1'b0);
		run_phase(32, 12, 12, 80, 1'b1);
		run_phase(CNT_W'(DEPTH), 0, 0, 6, 1'b0);
		run_phase(11'h7FF, 0, 0, 6, 1'b0);
		run_phase(3, 12, 12, 60, 1'b0);
		run_phase(1, 0, 0, 20, 1'b0);

		wait_drained();
		repeat (64) @(posedge clk);
		$display("Covered %0d request beats with sample counts from 0 to 2047, including a full memory.",
			beats_sent);
		$display("Loads, index and value queries, undefined modes, a long result hold and a drain ran.");
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
src/brsc_pkg.sv
src/brsc_if.sv
src/brsc_datapath.sv
src/brsc_ctrl.sv
src/bivariate_risk_set_count_top.sv
bench/brsc_risk_count_checker.sv
bench/tb_bivariate_risk_set_count_top.sv
